FILE: sv/cna_pkg.sv
// shared types, constants and helper functions for the complex arithmetic unit
// no dependencies
`default_nettype none

package cna_pkg;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_CONJ   = 4'd4;
    localparam logic [3:0] OP_TOPOL  = 4'd5;
    localparam logic [3:0] OP_TORECT = 4'd6;
    localparam logic [3:0] OP_PMUL   = 4'd7;
    localparam logic [3:0] OP_PDIV   = 4'd8;
    localparam logic [3:0] OP_PCONJ  = 4'd9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_RSVD    = 2'd3;

    // how the last stage forms the result
    localparam logic [2:0] KIND_DIRECT = 3'd0;
    localparam logic [2:0] KIND_DIV2   = 3'd1;
    localparam logic [2:0] KIND_DIV1   = 3'd2;
    localparam logic [2:0] KIND_POLAR  = 3'd3;
    localparam logic [2:0] KIND_RECT   = 3'd4;

    localparam int QW    = 33;        // quotient bits, one per cell
    localparam int NCELL = QW;
    localparam int DW    = 64;        // divisor and remainder width
    localparam int FMAX  = 24;
    localparam int NW    = DW + FMAX; // scaled numerator width
    localparam int XW    = 44;        // cordic x and y
    localparam int ZW    = 33;        // cordic angle
    localparam int GUARD_SHIFT = 8;
    localparam int GHW   = XW - 16 + 32;
    localparam int GLW   = 48;
    localparam int SMW   = 40;

    localparam logic [31:0] GAIN_INV     = 32'd2608131496;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN      = 32'h8000_0000;

    typedef struct packed {
        logic                 ovf;
        logic [31:0]          val;
    } t_sat;

    typedef struct packed {
        logic                 valid;
        logic [3:0]           op;
        logic [2:0]           kind;
        logic [31:0]          r0;
        logic [31:0]          r1;
        logic [1:0]           st;
        logic                 rot;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [DW-1:0]        d;
        logic [DW-1:0]        rem0;
        logic [DW-1:0]        rem1;
        logic [QW-1:0]        qn0;
        logic [QW-1:0]        qn1;
        logic                 neg0;
        logic                 neg1;
        logic                 ovf0;
        logic                 ovf1;
    } t_cell;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] a;
        unique case (idx)
            0:  a = 32'h2000_0000;
            1:  a = 32'h12E4_051E;
            2:  a = 32'h09FB_385B;
            3:  a = 32'h0511_11D4;
            4:  a = 32'h028B_0D43;
            5:  a = 32'h0145_D7E1;
            6:  a = 32'h00A2_F61E;
            7:  a = 32'h0051_7C55;
            8:  a = 32'h0028_BE53;
            9:  a = 32'h0014_5F2F;
            10: a = 32'h000A_2F98;
            11: a = 32'h0005_17CC;
            12: a = 32'h0002_8BE6;
            13: a = 32'h0001_45F3;
            14: a = 32'h0000_A2FA;
            15: a = 32'h0000_517D;
            16: a = 32'h0000_28BE;
            17: a = 32'h0000_145F;
            18: a = 32'h0000_0A30;
            19: a = 32'h0000_0518;
            20: a = 32'h0000_028C;
            21: a = 32'h0000_0146;
            22: a = 32'h0000_00A3;
            23: a = 32'h0000_0051;
            24: a = 32'h0000_0029;
            25: a = 32'h0000_0014;
            26: a = 32'h0000_000A;
            27: a = 32'h0000_0005;
            28: a = 32'h0000_0003;
            29: a = 32'h0000_0001;
            30: a = 32'h0000_0001;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

    function automatic t_sat sat_wide(input logic signed [64:0] v);
        t_sat r;
        r.ovf = 1'b0;
        r.val = v[31:0];
        if (v > 65'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = S32_MAX;
        end else if (v < -65'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = S32_MIN;
        end
        return r;
    endfunction

    // sign and magnitude to a saturated 32-bit value
    function automatic t_sat sat_mag(input logic neg, input logic [SMW-1:0] m);
        t_sat r;
        r.ovf = 1'b0;
        if (!neg) begin
            r.val = m[31:0];
            if (m > SMW'(32'h7FFF_FFFF)) begin
                r.ovf = 1'b1;
                r.val = S32_MAX;
            end
        end else begin
            r.val = 32'd0 - m[31:0];
            if (m > SMW'(33'h0_8000_0000)) begin
                r.ovf = 1'b1;
                r.val = S32_MIN;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] toward(input logic [31:0] a);
        logic [31:0] r;
        if (a == 32'd0) begin
            r = 32'd0;
        end else if (a[31]) begin
            r = S32_MIN;
        end else begin
            r = S32_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cna_pre.sv
// input stages: operand products, then setup of the cell chain and direct results
// depends on cna_pkg
`default_nettype none

module cna_pre import cna_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [3:0]  i_operation,
    input  wire logic [31:0] i_a_first,
    input  wire logic [31:0] i_a_second,
    input  wire logic [31:0] i_b_first,
    input  wire logic [31:0] i_b_second,
    output t_cell            o_cell
);

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] qn;
        logic          ovf;
    } t_lane;

    logic              r_a_valid;
    logic [3:0]        r_op;
    logic signed [31:0] r_ar, r_ai, r_br, r_bi;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bbr, r_p_bbi;

    logic              r_b_valid;
    t_cell             r_b;
    t_cell             n_b;

    logic signed [32:0] w_sum_r, w_sum_i, w_dif_r, w_dif_i, w_neg_i;
    logic signed [64:0] w_mr, w_mi, w_pr, w_n0, w_n1;
    logic [64:0]        w_abs0, w_abs1;
    logic [DW-1:0]      w_d3;
    logic [31:0]        w_abs_ar, w_abs_br;
    logic signed [XW-1:0] w_xa, w_ya;
    logic [31:0]        w_q, w_u;
    t_lane              w_l0, w_l1, w_lp;

    // scaled numerator split into starting remainder and bits still to bring in
    function automatic t_lane lane_init(input logic [DW-1:0] mag, input logic [DW-1:0] d);
        t_lane            l;
        logic [NW-1:0]    nn;
        logic [NW-QW-1:0] ri;
        nn    = {{(NW-DW){1'b0}}, mag} << FRACTION_BITS;
        ri    = nn[NW-1:QW];
        l.ovf = {{(DW-(NW-QW)){1'b0}}, ri} >= d;
        l.rem = l.ovf ? '0 : {{(DW-(NW-QW)){1'b0}}, ri};
        l.qn  = nn[QW-1:0];
        return l;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op    <= i_operation;
            r_ar    <= i_a_first;
            r_ai    <= i_a_second;
            r_br    <= i_b_first;
            r_bi    <= i_b_second;
            r_p_rr  <= $signed(i_a_first)  * $signed(i_b_first);
            r_p_ii  <= $signed(i_a_second) * $signed(i_b_second);
            r_p_ri  <= $signed(i_a_first)  * $signed(i_b_second);
            r_p_ir  <= $signed(i_a_second) * $signed(i_b_first);
            r_p_bbr <= $signed(i_b_first)  * $signed(i_b_first);
            r_p_bbi <= $signed(i_b_second) * $signed(i_b_second);
        end
    end

    always_comb begin
        w_sum_r = {r_ar[31], r_ar} + {r_br[31], r_br};
        w_sum_i = {r_ai[31], r_ai} + {r_bi[31], r_bi};
        w_dif_r = {r_ar[31], r_ar} - {r_br[31], r_br};
        w_dif_i = {r_ai[31], r_ai} - {r_bi[31], r_bi};
        w_neg_i = 33'd0 - {r_ai[31], r_ai};

        w_mr = {r_p_rr[63], r_p_rr} - {r_p_ii[63], r_p_ii};
        w_mi = {r_p_ri[63], r_p_ri} + {r_p_ir[63], r_p_ir};
        w_pr = {r_p_rr[63], r_p_rr};

        w_n0   = {r_p_rr[63], r_p_rr} + {r_p_ii[63], r_p_ii};
        w_n1   = {r_p_ir[63], r_p_ir} - {r_p_ri[63], r_p_ri};
        w_abs0 = w_n0[64] ? (~w_n0 + 65'd1) : w_n0;
        w_abs1 = w_n1[64] ? (~w_n1 + 65'd1) : w_n1;
        w_d3   = $unsigned(r_p_bbr) + $unsigned(r_p_bbi);

        w_abs_ar = r_ar[31] ? (32'd0 - r_ar) : r_ar;
        w_abs_br = r_br[31] ? (32'd0 - r_br) : r_br;

        w_l0 = lane_init(w_abs0[DW-1:0], w_d3);
        w_l1 = lane_init(w_abs1[DW-1:0], w_d3);
        w_lp = lane_init({{(DW-32){1'b0}}, w_abs_ar}, {{(DW-32){1'b0}}, w_abs_br});

        w_xa = {{(XW-32){r_ar[31]}}, r_ar} <<< GUARD_SHIFT;
        w_ya = {{(XW-32){r_ai[31]}}, r_ai} <<< GUARD_SHIFT;
        // angles in the left half plane fold over by half a turn
        w_q  = r_ai + TURN_QUARTER;
        w_u  = w_q[31] ? (r_ai ^ TURN_HALF) : r_ai;
    end

    always_comb begin
        t_sat s0;
        t_sat s1;
        s0 = '0;
        s1 = '0;
        n_b       = '0;
        n_b.valid = r_a_valid;
        n_b.op    = r_op;
        n_b.kind  = KIND_DIRECT;
        n_b.d     = w_d3;
        n_b.rem0  = w_l0.rem;
        n_b.qn0   = w_l0.qn;
        n_b.ovf0  = w_l0.ovf;
        n_b.neg0  = w_n0[64];
        n_b.rem1  = w_l1.rem;
        n_b.qn1   = w_l1.qn;
        n_b.ovf1  = w_l1.ovf;
        n_b.neg1  = w_n1[64];
        unique case (r_op)
            OP_ADD: begin
                s0 = sat_wide({{32{w_sum_r[32]}}, w_sum_r});
                s1 = sat_wide({{32{w_sum_i[32]}}, w_sum_i});
            end
            OP_SUB: begin
                s0 = sat_wide({{32{w_dif_r[32]}}, w_dif_r});
                s1 = sat_wide({{32{w_dif_i[32]}}, w_dif_i});
            end
            OP_MUL: begin
                s0 = sat_wide(w_mr >>> FRACTION_BITS);
                s1 = sat_wide(w_mi >>> FRACTION_BITS);
            end
            OP_DIV: begin
                if (w_d3 == '0) begin
                    n_b.st = ST_DIVZERO;
                    s0.val = toward(r_ar);
                    s1.val = toward(r_ai);
                end else begin
                    n_b.kind = KIND_DIV2;
                end
            end
            OP_CONJ: begin
                s0.val = r_ar;
                s1 = sat_wide({{32{w_neg_i[32]}}, w_neg_i});
            end
            OP_TOPOL: begin
                n_b.kind = KIND_POLAR;
                n_b.zero = (r_ar == 32'sd0) && (r_ai == 32'sd0);
                n_b.x    = r_ar[31] ? -w_xa : w_xa;
                n_b.y    = r_ar[31] ? -w_ya : w_ya;
                n_b.z    = r_ar[31] ? {1'b0, TURN_HALF} : '0;
            end
            OP_TORECT: begin
                n_b.kind = KIND_RECT;
                n_b.rot  = 1'b1;
                n_b.x    = w_q[31] ? -w_xa : w_xa;
                n_b.z    = {w_u[31], w_u};
            end
            OP_PMUL: begin
                s0 = sat_wide(w_pr >>> FRACTION_BITS);
                s1.val = r_ai + r_bi;
            end
            OP_PDIV: begin
                s1.val = r_ai - r_bi;
                n_b.d    = {{(DW-32){1'b0}}, w_abs_br};
                n_b.rem0 = w_lp.rem;
                n_b.qn0  = w_lp.qn;
                n_b.ovf0 = w_lp.ovf;
                n_b.neg0 = r_ar[31] ^ r_br[31];
                if (r_br == 32'sd0) begin
                    n_b.st = ST_DIVZERO;
                    s0.val = toward(r_ar);
                end else begin
                    n_b.kind = KIND_DIV1;
                end
            end
            OP_PCONJ: begin
                s0.val = r_ar;
                s1.val = 32'd0 - r_ai;
            end
            default: begin
                s0 = '0;
                s1 = '0;
            end
        endcase
        n_b.r0 = s0.val;
        n_b.r1 = s1.val;
        if (s0.ovf || s1.ovf) begin
            n_b.st = ST_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= n_b.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    always_comb begin
        o_cell       = r_b;
        o_cell.valid = r_b_valid;
    end

endmodule

`default_nettype wire

FILE: sv/cna_cell.sv
// one chain cell: a cordic micro-rotation while IDX is below ITERS, and one quotient bit for both divider lanes
// depends on cna_pkg
`default_nettype none

module cna_cell import cna_pkg::*; #(
    parameter int IDX   = 0,
    parameter int ITERS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_cell     i_cell,
    output t_cell     o_cell
);

    logic  r_valid;
    t_cell r_cell;
    t_cell n_cell;

    logic signed [XW-1:0] w_x, w_y, w_dx, w_dy;
    logic signed [ZW-1:0] w_z, w_a;
    logic                 w_pos;
    logic [DW:0]          w_t0, w_t1, w_s0, w_s1;
    logic                 w_ge0, w_ge1;

    always_comb begin
        n_cell = i_cell;
        w_x    = i_cell.x;
        w_y    = i_cell.y;
        w_z    = i_cell.z;
        w_dx   = w_x >>> IDX;
        w_dy   = w_y >>> IDX;
        w_a    = {1'b0, atan_turn(IDX)};
        // rotate toward zero angle, or toward the x axis when vectoring
        w_pos  = i_cell.rot ? ~w_z[ZW-1] : w_y[XW-1];
        if (IDX < ITERS) begin
            if (w_pos) begin
                n_cell.x = w_x - w_dy;
                n_cell.y = w_y + w_dx;
                n_cell.z = w_z - w_a;
            end else begin
                n_cell.x = w_x + w_dy;
                n_cell.y = w_y - w_dx;
                n_cell.z = w_z + w_a;
            end
        end

        w_t0  = {i_cell.rem0, i_cell.qn0[QW-1]};
        w_t1  = {i_cell.rem1, i_cell.qn1[QW-1]};
        w_s0  = w_t0 - {1'b0, i_cell.d};
        w_s1  = w_t1 - {1'b0, i_cell.d};
        w_ge0 = w_t0 >= {1'b0, i_cell.d};
        w_ge1 = w_t1 >= {1'b0, i_cell.d};
        n_cell.rem0 = w_ge0 ? w_s0[DW-1:0] : w_t0[DW-1:0];
        n_cell.rem1 = w_ge1 ? w_s1[DW-1:0] : w_t1[DW-1:0];
        n_cell.qn0  = {i_cell.qn0[QW-2:0], w_ge0};
        n_cell.qn1  = {i_cell.qn1[QW-2:0], w_ge1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    always_comb begin
        o_cell       = r_cell;
        o_cell.valid = r_valid;
    end

endmodule

`default_nettype wire

FILE: sv/cna_post.sv
// output stages: cordic gain correction, quotient saturation, result select and output register
// depends on cna_pkg
`default_nettype none

module cna_post import cna_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  t_cell            i_cell,
    output logic             o_valid,
    output logic [31:0]      o_result_first,
    output logic [31:0]      o_result_second,
    output logic [1:0]       o_status,
    output logic [3:0]       o_op
);

    logic [XW-1:0]  w_mx, w_my;

    logic           r_p_valid;
    t_cell          r_c;
    logic [GHW-1:0] r_hx, r_hy;
    logic [GLW-1:0] r_lx, r_ly;

    logic [GHW:0]   w_gx, w_gy;
    t_sat           w_sx, w_sy, w_q0, w_q1;
    logic [31:0]    n_r0, n_r1;
    logic [1:0]     n_st;

    always_comb begin
        w_mx = i_cell.x[XW-1] ? (XW'(0) - i_cell.x) : i_cell.x;
        w_my = i_cell.y[XW-1] ? (XW'(0) - i_cell.y) : i_cell.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c  <= i_cell;
            r_hx <= w_mx[XW-1:16] * GAIN_INV;
            r_lx <= w_mx[15:0] * GAIN_INV;
            r_hy <= w_my[XW-1:16] * GAIN_INV;
            r_ly <= w_my[15:0] * GAIN_INV;
        end
    end

    always_comb begin
        w_gx = {1'b0, r_hx} + {{(GHW+1-(GLW-16)){1'b0}}, r_lx[GLW-1:16]};
        w_gy = {1'b0, r_hy} + {{(GHW+1-(GLW-16)){1'b0}}, r_ly[GLW-1:16]};
        w_sx = sat_mag(r_c.x[XW-1], SMW'(w_gx[GHW:16+GUARD_SHIFT]));
        w_sy = sat_mag(r_c.y[XW-1], SMW'(w_gy[GHW:16+GUARD_SHIFT]));
        w_q0 = sat_mag(r_c.neg0, r_c.ovf0 ? {SMW{1'b1}} : SMW'(r_c.qn0));
        w_q1 = sat_mag(r_c.neg1, r_c.ovf1 ? {SMW{1'b1}} : SMW'(r_c.qn1));

        n_r0 = 32'd0;
        n_r1 = 32'd0;
        n_st = ST_OK;
        unique case (r_c.kind)
            KIND_DIRECT: begin
                n_r0 = r_c.r0;
                n_r1 = r_c.r1;
                n_st = r_c.st;
            end
            KIND_DIV2: begin
                n_r0 = w_q0.val;
                n_r1 = w_q1.val;
                n_st = (w_q0.ovf || w_q1.ovf) ? ST_OVF : ST_OK;
            end
            KIND_DIV1: begin
                n_r0 = w_q0.val;
                n_r1 = r_c.r1;
                n_st = w_q0.ovf ? ST_OVF : ST_OK;
            end
            KIND_POLAR: begin
                n_r0 = w_sx.val;
                n_r1 = r_c.zero ? 32'd0 : r_c.z[31:0];
                n_st = w_sx.ovf ? ST_OVF : ST_OK;
            end
            KIND_RECT: begin
                n_r0 = w_sx.val;
                n_r1 = w_sy.val;
                n_st = (w_sx.ovf || w_sy.ovf) ? ST_OVF : ST_OK;
            end
            default: begin
                n_r0 = 32'd0;
                n_r1 = 32'd0;
                n_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_result_first  <= n_r0;
            o_result_second <= n_r1;
            o_status        <= n_st;
            o_op            <= r_c.op;
        end
    end

endmodule

`default_nettype wire

FILE: sv/complex_number_alu.sv
// Complex arithmetic unit: cartesian and polar ops on Q16.16 operands, one word per cycle
// unless stalled. Fully pipelined: two input stages (products, setup), a chain of 33 cells
// that each produce one quotient bit of both divider lanes, the first CORDIC_ITERATIONS also
// one cordic micro-rotation, then a gain-correction stage and the output register. The chain
// length is set by the 33 quotient bits of the divider. A stalled output freezes the whole
// pipeline; while the output is free or being taken a new word is accepted every cycle.
// depends on cna_pkg, cna_pre, cna_cell, cna_post
`default_nettype none

module complex_number_alu import cna_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 24,
    parameter int FRACTION_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_operation,
    input  wire logic [31:0] i_a_first,
    input  wire logic [31:0] i_a_second,
    input  wire logic [31:0] i_b_first,
    input  wire logic [31:0] i_b_second,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result_first,
    output logic [31:0]      o_result_second,
    output logic [1:0]       o_status
);

    logic             w_en;
    t_cell            w_chain [NCELL+1];
    logic [NCELL-1:0] w_valid_vec;
    logic [3:0]       w_out_op;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    cna_pre #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_a_first   (i_a_first),
        .i_a_second  (i_a_second),
        .i_b_first   (i_b_first),
        .i_b_second  (i_b_second),
        .o_cell      (w_chain[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cna_cell #(
            .IDX   (k),
            .ITERS (CORDIC_ITERATIONS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
        assign w_valid_vec[k] = w_chain[k+1].valid;
    end

    cna_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_cell          (w_chain[NCELL]),
        .o_valid         (o_valid),
        .o_result_first  (o_result_first),
        .o_result_second (o_result_second),
        .o_status        (o_status),
        .o_op            (w_out_op)
    );

    // a stalled chain holds every word in place
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid_vec))
        else $error("cell chain moved during stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != ST_RSVD)
        else $error("reserved status code on output");

    a_divzero_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZERO) |-> (w_out_op == OP_DIV || w_out_op == OP_PDIV))
        else $error("divide-by-zero status on a non-divide word");

    a_chain_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_chain[NCELL].valid) |=> $past(w_en) && w_chain[NCELL].valid == 1'b1
            || !$past(w_chain[NCELL-1].valid))
        else $error("word lost at end of cell chain");

endmodule

`default_nettype wire
